// ===== rtl/grid_flood_fill_move_assert.svh =====
// ----------------------------------------------------------------------------
// grid_flood_fill_move assertion macros
// Shared property forms for the flood-fill block's in-design checks.
// ----------------------------------------------------------------------------
`ifndef GRID_FLOOD_FILL_MOVE_ASSERT_SVH
`define GRID_FLOOD_FILL_MOVE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GFFM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GFFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gffm_pkg.sv =====
// ----------------------------------------------------------------------------
// gffm_pkg
// Types and constants shared by the flood-fill grid modules.
// ----------------------------------------------------------------------------
package gffm_pkg;

   localparam int GRID_MAX = 16;
   localparam int CELLS    = GRID_MAX * GRID_MAX;
   localparam int FLOOD_W  = $clog2(CELLS);
   localparam int ROW_W    = $clog2(GRID_MAX);
   localparam int COORD_W  = 4;
   localparam int COLOR_W  = 3;
   localparam int SIZE_W   = 5;
   localparam int MOVES_W  = 8;
   localparam int CSR_ADDR_W = 4;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MOVE = 1'b1;

   localparam logic [1:0] REG_GRID_SIZE = 2'd0;
   localparam logic [1:0] REG_MAX_MOVES = 2'd1;
   localparam logic [1:0] REG_START_ROW = 2'd2;
   localparam logic [1:0] REG_START_COL = 2'd3;

   typedef enum logic [1:0] {
      STATUS_CONTINUE = 2'd0,
      STATUS_SUCCESS  = 2'd1,
      STATUS_FAILED   = 2'd2,
      STATUS_LOADED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLOOD,
      ST_PAINT,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  grid_size;
      logic [MOVES_W-1:0] max_moves;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] start_col;
   } cfg_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic               load_en;
      logic [COORD_W-1:0] load_row;
      logic [COORD_W-1:0] load_col;
      logic [COLOR_W-1:0] load_color;
      logic               load_blocked;
      logic               seed;
      logic               step;
      logic               paint;
      logic [COLOR_W-1:0] new_color;
      logic [SIZE_W-1:0]  grid_used;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] start_col;
   } arr_ctl_type;

endpackage

// ===== rtl/gffm_cell.sv =====
// ----------------------------------------------------------------------------
// gffm_cell
// One grid cell: color, obstacle mark and flood mark.
// ----------------------------------------------------------------------------
module gffm_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gffm_pkg::arr_ctl_type                ctl,
   input  logic [gffm_pkg::COORD_W-1:0]         my_row,
   input  logic [gffm_pkg::COORD_W-1:0]         my_col,
   input  logic [3:0]                           nb_mark,   // north, south, west, east
   input  logic [3:0][gffm_pkg::COLOR_W-1:0]    nb_color,
   output logic                                 mark,
   output logic [gffm_pkg::COLOR_W-1:0]         color,
   output logic                                 ok
);

   logic                          mark_ff, mark_in;
   logic [gffm_pkg::COLOR_W-1:0]  color_ff, color_in;
   logic                          obst_ff, obst_in;
   logic                          in_use;
   logic                          hit;
   logic                          is_start;
   logic                          joins;

   assign in_use = (gffm_pkg::SIZE_W'(my_row) < ctl.grid_used) &&
                   (gffm_pkg::SIZE_W'(my_col) < ctl.grid_used);
   assign hit      = ctl.load_en && (ctl.load_row == my_row) && (ctl.load_col == my_col);
   assign is_start = (ctl.start_row == my_row) && (ctl.start_col == my_col);

   // A free cell joins when a marked neighbor carries its own color:
   // every marked cell holds the start cell's old color.
   always_comb begin
      joins = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (nb_mark[i] && (nb_color[i] == color_ff)) begin
            joins = 1'b1;
         end
      end
      joins = joins && in_use && !obst_ff;
   end

   always_comb begin
      if (ctl.seed) begin
         mark_in = is_start && in_use && !obst_ff;
      end else if (ctl.step) begin
         mark_in = mark_ff || joins;
      end else begin
         mark_in = mark_ff;
      end
   end

   always_comb begin
      color_in = color_ff;
      obst_in  = obst_ff;
      if (hit) begin
         color_in = ctl.load_color;
         obst_in  = ctl.load_blocked;
      end else if (ctl.paint && mark_ff) begin
         color_in = ctl.new_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff <= color_in;
      obst_ff  <= obst_in;
   end

   assign mark  = mark_ff;
   assign color = color_ff;
   assign ok    = !in_use || obst_ff || (color_ff == ctl.new_color);

endmodule

// ===== rtl/gffm_array.sv =====
// ----------------------------------------------------------------------------
// gffm_array
// Square mesh of cells; each cell trades flood marks with its up to four neighbors.
// ----------------------------------------------------------------------------
module gffm_array (
   input  logic                            clock,
   input  logic                            reset,
   input  gffm_pkg::arr_ctl_type           ctl,
   output logic [gffm_pkg::GRID_MAX-1:0]   row_ok
);

   localparam int N = gffm_pkg::GRID_MAX;

   logic                          mark_w  [N][N];
   logic [gffm_pkg::COLOR_W-1:0]  color_w [N][N];
   logic [N-1:0][N-1:0]           ok_w;

   for (genvar r = 0; r < N; r++) begin : g_row
      for (genvar c = 0; c < N; c++) begin : g_col
         logic [3:0]                          nbm;
         logic [3:0][gffm_pkg::COLOR_W-1:0]   nbc;

         if (r > 0) begin : g_n
            assign nbm[0] = mark_w[r-1][c];
            assign nbc[0] = color_w[r-1][c];
         end else begin : g_n_edge
            assign nbm[0] = 1'b0;
            assign nbc[0] = '0;
         end
         if (r < N-1) begin : g_s
            assign nbm[1] = mark_w[r+1][c];
            assign nbc[1] = color_w[r+1][c];
         end else begin : g_s_edge
            assign nbm[1] = 1'b0;
            assign nbc[1] = '0;
         end
         if (c > 0) begin : g_w
            assign nbm[2] = mark_w[r][c-1];
            assign nbc[2] = color_w[r][c-1];
         end else begin : g_w_edge
            assign nbm[2] = 1'b0;
            assign nbc[2] = '0;
         end
         if (c < N-1) begin : g_e
            assign nbm[3] = mark_w[r][c+1];
            assign nbc[3] = color_w[r][c+1];
         end else begin : g_e_edge
            assign nbm[3] = 1'b0;
            assign nbc[3] = '0;
         end

         gffm_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .my_row   (gffm_pkg::COORD_W'(r)),
            .my_col   (gffm_pkg::COORD_W'(c)),
            .nb_mark  (nbm),
            .nb_color (nbc),
            .mark     (mark_w[r][c]),
            .color    (color_w[r][c]),
            .ok       (ok_w[r][c])
         );
      end

      assign row_ok[r] = &ok_w[r];
   end

endmodule

// ===== rtl/gffm_ctrl.sv =====
// ----------------------------------------------------------------------------
// gffm_ctrl
// Sequencer: load/move decode, flood and check counters, move count, result.
// ----------------------------------------------------------------------------
`include "grid_flood_fill_move_assert.svh"

module gffm_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,
   input  gffm_pkg::cfg_type               cfg,
   input  logic [gffm_pkg::GRID_MAX-1:0]   row_ok,
   output gffm_pkg::arr_ctl_type           ctl
);

   localparam logic [gffm_pkg::FLOOD_W-1:0] FLOOD_LAST = gffm_pkg::FLOOD_W'(gffm_pkg::CELLS - 1);
   localparam logic [gffm_pkg::ROW_W-1:0]   ROW_LAST   = gffm_pkg::ROW_W'(gffm_pkg::GRID_MAX - 1);

   gffm_pkg::state_type             state_ff, state_in;
   logic [gffm_pkg::FLOOD_W-1:0]    flood_cnt_ff;
   logic [gffm_pkg::ROW_W-1:0]      row_cnt_ff;
   logic                            all_ok_ff;
   logic                            fail_ff;
   logic [gffm_pkg::MOVES_W-1:0]    count_ff, count_in;
   logic [gffm_pkg::COLOR_W-1:0]    new_color_ff;
   logic                            rsp_valid_ff;
   gffm_pkg::status_type            rsp_status_ff;
   logic [gffm_pkg::MOVES_W-1:0]    rsp_moves_ff;

   logic                            accept;
   logic                            is_load;
   logic                            is_move;
   logic                            flood_end;
   logic                            check_end;
   logic                            final_ok;
   logic [gffm_pkg::SIZE_W-1:0]     grid_used;

   assign req_tready = (state_ff == gffm_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_load    = accept && (req_tuser == gffm_pkg::CMD_LOAD);
   assign is_move    = accept && (req_tuser == gffm_pkg::CMD_MOVE);
   assign flood_end  = (state_ff == gffm_pkg::ST_FLOOD) && (flood_cnt_ff == FLOOD_LAST);
   assign check_end  = (state_ff == gffm_pkg::ST_CHECK) && (row_cnt_ff == ROW_LAST);
   assign final_ok   = all_ok_ff && row_ok[row_cnt_ff];
   assign count_in   = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   assign grid_used  = (cfg.grid_size > gffm_pkg::SIZE_W'(gffm_pkg::GRID_MAX)) ?
                       gffm_pkg::SIZE_W'(gffm_pkg::GRID_MAX) : cfg.grid_size;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gffm_pkg::ST_IDLE: begin
            if (is_move) begin
               state_in = gffm_pkg::ST_FLOOD;
            end
         end
         gffm_pkg::ST_FLOOD: begin
            if (flood_end) begin
               state_in = gffm_pkg::ST_PAINT;
            end
         end
         gffm_pkg::ST_PAINT: begin
            state_in = gffm_pkg::ST_CHECK;
         end
         gffm_pkg::ST_CHECK: begin
            if (check_end) begin
               state_in = gffm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gffm_pkg::ST_IDLE;
         end
      endcase
   end

   // cell array controls
   always_comb begin
      ctl.load_en      = is_load;
      ctl.load_row     = req_tdata[3:0];
      ctl.load_col     = req_tdata[7:4];
      ctl.load_color   = req_tdata[10:8];
      ctl.load_blocked = req_tdata[11];
      ctl.seed         = is_move;
      ctl.step         = (state_ff == gffm_pkg::ST_FLOOD);
      ctl.paint        = (state_ff == gffm_pkg::ST_PAINT);
      ctl.new_color    = new_color_ff;
      ctl.grid_used    = grid_used;
      ctl.start_row    = cfg.start_row;
      ctl.start_col    = cfg.start_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gffm_pkg::ST_IDLE;
         flood_cnt_ff <= '0;
         row_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flood_cnt_ff <= (state_ff == gffm_pkg::ST_FLOOD) ? flood_cnt_ff + 1'b1 : '0;
         row_cnt_ff   <= (state_ff == gffm_pkg::ST_CHECK) ? row_cnt_ff + 1'b1 : '0;
         if (is_move) begin
            count_ff <= count_in;
         end
         if (is_load || check_end) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (is_move) begin
         new_color_ff <= req_tdata[14:12];
         fail_ff      <= (count_in >= cfg.max_moves);
      end
      if (state_ff == gffm_pkg::ST_PAINT) begin
         all_ok_ff <= 1'b1;
      end else if (state_ff == gffm_pkg::ST_CHECK) begin
         all_ok_ff <= final_ok;
      end
      if (is_load) begin
         rsp_status_ff <= gffm_pkg::STATUS_LOADED;
         rsp_moves_ff  <= count_ff;
      end else if (check_end) begin
         rsp_moves_ff <= count_ff;
         if (fail_ff) begin
            rsp_status_ff <= gffm_pkg::STATUS_FAILED;
         end else if (final_ok) begin
            rsp_status_ff <= gffm_pkg::STATUS_SUCCESS;
         end else begin
            rsp_status_ff <= gffm_pkg::STATUS_CONTINUE;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_moves_ff, rsp_status_ff};

   `GFFM_ASSERT_NEXT(a_move_starts_flood, clock, reset, is_move, state_ff == gffm_pkg::ST_FLOOD, "move transfer did not start the flood")
   `GFFM_ASSERT_NEXT(a_flood_to_paint, clock, reset, flood_end, state_ff == gffm_pkg::ST_PAINT, "flood did not end in paint")
   `GFFM_ASSERT_NOW(a_busy_no_rsp, clock, reset, state_ff != gffm_pkg::ST_IDLE, !rsp_valid_ff, "result pending while a move runs")
   `GFFM_ASSERT_NEXT(a_check_gives_rsp, clock, reset, check_end, rsp_valid_ff && (state_ff == gffm_pkg::ST_IDLE), "check end gave no result")
   `GFFM_ASSERT_NEXT(a_load_rsp, clock, reset, is_load, rsp_valid_ff && (rsp_status_ff == gffm_pkg::STATUS_LOADED), "load transfer gave no loaded result")

endmodule

// ===== rtl/grid_flood_fill_move.sv =====
// ----------------------------------------------------------------------------
// grid_flood_fill_move
// Colored square grid with obstacles, played by 4-connected flood fill.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per transfer. tuser = cmd (0 load a cell, 1 play a move).
//            Loads fill the grid before play; one result per item on rsp_*.
//   rsp_*  : status (0 continue, 1 success, 2 failed, 3 cell loaded) and the
//            move count after the item.
//   csr_*  : grid_size @0x0, max_moves @0x4, start_row @0x8, start_col @0xC.
//            Write only while no item is in flight.
// Operation: a load answers the cycle after its transfer. A move seeds the
//   start cell at its transfer, then the mesh grows the region one cell hop a
//   cycle until the flood counter has passed every cell (enough for any path),
//   paints it and ANDs the per-row completion flags one row a cycle; the
//   result is registered after the last row. Moves take one item at a time;
//   loads can stream one per cycle while rsp_tready stays high.
// Reset: registers take their reset values, the move count clears; cell
//   contents are undefined until loaded.
// Stall: the result sits in an output register until rsp_tready; the next
//   item is taken in the same cycle that the pending result is transferred.
// ----------------------------------------------------------------------------
module grid_flood_fill_move (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // cell_row, cell_col, cell_color,
                                                           // cell_blocked, move_color, pad
   input  logic                                req_tuser,  // cmd
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // status, moves_done, pad
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gffm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   gffm_pkg::cfg_type                 cfg_ff;
   gffm_pkg::arr_ctl_type             ctl;
   logic [gffm_pkg::GRID_MAX-1:0]     row_ok;
   logic                              csr_wr;
   logic [1:0]                        csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_size <= gffm_pkg::SIZE_W'(16);
         cfg_ff.max_moves <= gffm_pkg::MOVES_W'(30);
         cfg_ff.start_row <= '0;
         cfg_ff.start_col <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            gffm_pkg::REG_GRID_SIZE: cfg_ff.grid_size <= csr_pwdata[gffm_pkg::SIZE_W-1:0];
            gffm_pkg::REG_MAX_MOVES: cfg_ff.max_moves <= csr_pwdata[gffm_pkg::MOVES_W-1:0];
            gffm_pkg::REG_START_ROW: cfg_ff.start_row <= csr_pwdata[gffm_pkg::COORD_W-1:0];
            gffm_pkg::REG_START_COL: cfg_ff.start_col <= csr_pwdata[gffm_pkg::COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         gffm_pkg::REG_GRID_SIZE: csr_prdata = 32'(cfg_ff.grid_size);
         gffm_pkg::REG_MAX_MOVES: csr_prdata = 32'(cfg_ff.max_moves);
         gffm_pkg::REG_START_ROW: csr_prdata = 32'(cfg_ff.start_row);
         gffm_pkg::REG_START_COL: csr_prdata = 32'(cfg_ff.start_col);
         default:                 csr_prdata = '0;
      endcase
   end

   // sequencer: decode, counters, move count and result register
   gffm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cfg        (cfg_ff),
      .row_ok     (row_ok),
      .ctl        (ctl)
   );

   // cell mesh: storage, flood propagation, paint and per-row completion
   gffm_array u_array (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .row_ok (row_ok)
   );

endmodule
